/* hdl/aedl_pkg.sv */
// Package with shared types, register codes and defaults for the audio echo delay line.
`default_nettype none

package aedl_pkg;

  localparam int unsigned DELAY_DEPTH_DEF = 32768;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE        = 3'd0,
    REG_DELAY       = 3'd1,
    REG_ECHO_GAIN   = 3'd2,
    REG_FEEDFORWARD = 3'd3,
    REG_FEEDBACK    = 3'd4,
    REG_BLEND       = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_FEEDFORWARD = 2'd0,
    MODE_FEEDBACK    = 2'd1,
    MODE_UNIVERSAL   = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [15:0]        delay_samples;
    logic [15:0]        echo_gain;
    logic signed [15:0] feedforward_coef;
    logic signed [15:0] feedback_coef;
    logic signed [15:0] blend_coef;
  } cfg_t;

  localparam logic [15:0] DELAY_RST = 16'd1;
  localparam logic [15:0] GAIN_RST  = 16'd16384;
  localparam logic [15:0] BLEND_RST = 16'd16384;
  localparam logic [16:0] GAIN_ONE  = 17'd32768;

  typedef struct packed {
    logic accept;
    logic read;
    logic mul1;
    logic sum1;
    logic mul2;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

/* hdl/aedl_ctrl.sv */
// Controller state machine that sequences one sample through the datapath.
`default_nettype none

module aedl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  input  aedl_pkg::status_t stat_i,
  output aedl_pkg::cmd_t    cmd_o
);
  import aedl_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_MUL1 = 3'd2;
  localparam logic [2:0] ST_SUM1 = 3'd3;
  localparam logic [2:0] ST_MUL2 = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0] state_q, state_d;

  assign s_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = ST_SUM1;
      end
      ST_SUM1: begin
        cmd_o.sum1 = 1'b1;
        state_d    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/aedl_dp.sv */
// Datapath with the delay memory, pointers, multipliers, saturation and output register.
`default_nettype none

module aedl_dp #(
  parameter int unsigned DELAY_DEPTH = aedl_pkg::DELAY_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = aedl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  aedl_pkg::cmd_t          cmd_i,
  output aedl_pkg::status_t       stat_o,
  input  aedl_pkg::cfg_t          cfg_i,
  input  logic [SAMPLE_BITS-1:0]  in_sample_i,
  input  logic                    start_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [SAMPLE_BITS-1:0]  out_sample_o
);
  import aedl_pkg::*;

  localparam int unsigned AW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int unsigned FW = $clog2(DELAY_DEPTH + 1);
  localparam int unsigned LW = (FW > 16) ? FW : 16;
  localparam int unsigned XW = LW + 1;
  localparam int unsigned PA = SAMPLE_BITS + 18;
  localparam int unsigned PB = SAMPLE_BITS + 16;

  logic [SAMPLE_BITS-1:0] mem [DELAY_DEPTH];

  logic [AW-1:0]                 wp_q, rd_addr_q, rd_addr_d;
  logic [FW-1:0]                 fill_q, fill_eff;
  logic [LW-1:0]                 dl;
  logic [XW-1:0]                 rd_x;
  logic                          hit_q;
  logic                          out_valid_q;
  logic [SAMPLE_BITS-1:0]        out_q;
  logic [SAMPLE_BITS-1:0]        rd_data_q;
  logic signed [SAMPLE_BITS-1:0] x_q, d_sel, h_q, y_uni, y_out, store;
  logic signed [PA-1:0]          pa_q, pa_sh;
  logic signed [PB-1:0]          pb_q, pc_q;
  logic signed [17:0]            coef_a;
  logic [16:0]                   gain;
  logic                          is_uni;

  function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [PA:0] v);
    logic in_range;
    in_range = (&v[PA:SAMPLE_BITS-1]) || !(|v[PA:SAMPLE_BITS-1]);
    if (in_range) begin
      return v[SAMPLE_BITS-1:0];
    end else if (v[PA]) begin
      return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

  always_comb begin
    dl = LW'(cfg_i.delay_samples);
    if (dl == '0) begin
      dl = LW'(1);
    end
    if (dl > LW'(DELAY_DEPTH)) begin
      dl = LW'(DELAY_DEPTH);
    end
  end

  assign fill_eff  = start_i ? '0 : fill_q;
  assign rd_x      = (XW'(wp_q) >= XW'(dl)) ? (XW'(wp_q) - XW'(dl))
                                            : (XW'(wp_q) + XW'(DELAY_DEPTH) - XW'(dl));
  assign rd_addr_d = rd_x[AW-1:0];

  assign is_uni = (cfg_i.mode == MODE_UNIVERSAL);
  assign gain   = (cfg_i.echo_gain > GAIN_ONE[15:0] && cfg_i.echo_gain != 16'd0)
                  ? GAIN_ONE : {1'b0, cfg_i.echo_gain};
  assign coef_a = is_uni ? {{2{cfg_i.feedback_coef[15]}}, cfg_i.feedback_coef}
                         : {1'b0, gain};
  assign d_sel  = hit_q ? $signed(rd_data_q) : '0;
  assign pa_sh  = is_uni ? (pa_q >>> 14) : (pa_q >>> 15);
  assign y_uni  = sat((PA+1)'(pb_q >>> 14) + (PA+1)'(pc_q >>> 14));
  assign y_out  = is_uni ? y_uni : h_q;
  assign store  = (is_uni || cfg_i.mode == MODE_FEEDBACK) ? h_q : x_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      rd_data_q <= mem[rd_addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      mem[wp_q] <= store;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q       <= $signed(in_sample_i);
      rd_addr_q <= rd_addr_d;
      hit_q     <= (LW'(fill_eff) >= dl);
    end
    if (cmd_i.mul1) begin
      pa_q <= coef_a * d_sel;
      pb_q <= cfg_i.feedforward_coef * d_sel;
    end
    if (cmd_i.sum1) begin
      h_q <= sat((PA+1)'(pa_sh) + (PA+1)'(x_q));
    end
    if (cmd_i.mul2) begin
      pc_q <= cfg_i.blend_coef * h_q;
    end
    if (cmd_i.finish) begin
      out_q <= y_out;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        fill_q <= fill_eff;
      end else if (cmd_i.finish && fill_q < FW'(DELAY_DEPTH)) begin
        fill_q <= fill_q + 1'b1;
      end
      if (cmd_i.finish) begin
        wp_q <= (wp_q == AW'(DELAY_DEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_sample_o    = out_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    FW'(DELAY_DEPTH) >= fill_q) else $error("fill count above depth");
  a_wp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q < AW'(DELAY_DEPTH) || AW'(DELAY_DEPTH) == '0) else $error("write pointer out of range");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> !(out_valid_q && !out_ready_i)) else $error("pending result overwritten");
  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> out_valid_q) else $error("finished result not presented");
  a_wp_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.finish |=> $stable(wp_q)) else $error("write pointer moved without a store");

endmodule

`default_nettype wire

/* hdl/audio_echo_delay_line_top.sv */
// Top level of the audio echo delay line with stream ports and configuration registers.
// A request taken by the accept step passes the memory read, multiply, sum and second multiply
// steps of the controller; the finishing step, which waits while the output register holds
// an untaken result, loads the output register. One sample is processed at a time, so a new
// request is taken only after the finishing step. Reset loads the default configuration
// and clears the write pointer and fill count; unwritten slots read as zero.
`default_nettype none

module audio_echo_delay_line_top #(
  parameter int unsigned DELAY_DEPTH = aedl_pkg::DELAY_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = aedl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // in_sample
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,
  // start_of_buffer
  input  logic                                  s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // out_sample
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_axis_tdata,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [aedl_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [aedl_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import aedl_pkg::*;

  localparam int unsigned TDW = ((SAMPLE_BITS + 7) / 8) * 8;

  cfg_t                   cfg_q;
  cmd_t                   cmd;
  status_t                stat;
  logic [SAMPLE_BITS-1:0] out_sample;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode             <= MODE_FEEDFORWARD;
      cfg_q.delay_samples    <= DELAY_RST;
      cfg_q.echo_gain        <= GAIN_RST;
      cfg_q.feedforward_coef <= '0;
      cfg_q.feedback_coef    <= '0;
      cfg_q.blend_coef       <= BLEND_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_MODE:        cfg_q.mode             <= cfg_data_i[1:0];
        REG_DELAY:       cfg_q.delay_samples    <= cfg_data_i;
        REG_ECHO_GAIN:   cfg_q.echo_gain        <= cfg_data_i;
        REG_FEEDFORWARD: cfg_q.feedforward_coef <= cfg_data_i;
        REG_FEEDBACK:    cfg_q.feedback_coef    <= cfg_data_i;
        REG_BLEND:       cfg_q.blend_coef       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  aedl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  aedl_dp #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_i        (cfg_q),
    .in_sample_i  (s_axis_tdata[SAMPLE_BITS-1:0]),
    .start_i      (s_axis_tuser),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_sample_o (out_sample)
  );

  assign m_axis_tdata = TDW'(out_sample);

endmodule

`default_nettype wire

/* verif/tb_echo_pkg.sv */
// Scoreboard class that predicts and checks the echoed samples of the audio echo delay line.
package tb_echo_pkg;
  import aedl_pkg::*;

  localparam int LINE_DEPTH = DELAY_DEPTH_DEF;

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  class echo_line_checker;
    logic [1:0]         mode;
    logic [15:0]        delay;
    logic [15:0]        echo_gain;
    logic signed [15:0] feedforward;
    logic signed [15:0] feedback;
    logic signed [15:0] blend;

    logic signed [15:0] past_values [LINE_DEPTH];
    int                 wr_ptr;
    int                 filled;
    logic [15:0]        expected_echoes [$];
    int                 samples;
    int                 compared;
    int                 mismatches;

    function new();
      mode        = MODE_FEEDFORWARD;
      delay       = DELAY_RST;
      echo_gain   = GAIN_RST;
      feedforward = '0;
      feedback    = '0;
      blend       = BLEND_RST;
      wr_ptr      = 0;
      filled      = 0;
      samples     = 0;
      compared    = 0;
      mismatches  = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [15:0] value);
      case (idx)
        REG_MODE:        mode = value[1:0];
        REG_DELAY:       delay = value;
        REG_ECHO_GAIN:   echo_gain = value;
        REG_FEEDFORWARD: feedforward = value;
        REG_FEEDBACK:    feedback = value;
        REG_BLEND:       blend = value;
        default: ;
      endcase
    endfunction

    // An accepted request: work out the echoed sample and advance the line.
    function void take_sample(logic signed [15:0] x, logic restart);
      longint             lag;
      longint             gain;
      longint             d;
      longint             h;
      longint             y;
      logic signed [15:0] kept;
      lag = delay;
      if (lag == 0) lag = 1;
      if (lag > LINE_DEPTH) lag = LINE_DEPTH;
      gain = (echo_gain > 16'd32768) ? 32768 : echo_gain;
      if (restart) filled = 0;
      d = 0;
      if (filled >= lag) d = past_values[(wr_ptr + LINE_DEPTH - lag) % LINE_DEPTH];
      if (mode == MODE_UNIVERSAL) begin
        h = clip16(x + ((feedback * d) >>> 14));
        y = clip16(((feedforward * d) >>> 14) + ((blend * h) >>> 14));
        kept = h;
      end else begin
        y = clip16(x + ((gain * d) >>> 15));
        kept = (mode == MODE_FEEDBACK) ? y : x;
      end
      past_values[wr_ptr] = kept;
      wr_ptr = (wr_ptr + 1) % LINE_DEPTH;
      if (filled < LINE_DEPTH) filled++;
      expected_echoes.push_back(y[15:0]);
      samples++;
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("MISMATCH %0d: %s", mismatches, what);
    endtask

    task check_echo(logic [15:0] got);
      logic [15:0] want;
      if (expected_echoes.size() == 0) begin
        report_mismatch($sformatf("out_sample %h arrived with no request waiting", got));
      end else begin
        want = expected_echoes.pop_front();
        compared++;
        if (got !== want) begin
          report_mismatch($sformatf("out_sample %h, expected %h (result %0d)",
                                    got, want, compared));
        end
      end
    endtask
  endclass

endpackage

/* verif/tb_top.sv */
// Testbench top that drives the audio echo delay line and checks every echoed sample.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import aedl_pkg::*;
  import tb_echo_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_TARGET = 1850;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycles = 0;
  int settings = 0;
  int restarts = 0;

  echo_line_checker sb;

  audio_echo_delay_line_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycles, sb.expected_echoes.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_echo(m_axis_tdata);
  end

  // Called at a falling edge; returns at a falling edge with the request taken.
  task automatic send_sample(logic [15:0] sample, logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = sample;
    s_axis_tuser  = restart;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_sample(sample, restart);
    if (restart) restarts++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (sb.expected_echoes.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [15:0] value);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, value);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($signed($urandom_range(512)) - 256);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] pick_coef();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h4000;
      3: return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] pick_delay();
    case ($urandom_range(19))
      0: return 16'd0;
      1: return 16'd32768;
      2: return 16'hFFFF;
      3: return 16'($urandom_range(1200, 100));
      default: return 16'($urandom_range(40, 1));
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'd32768;
      2: return 16'hFFFF;
      3: return 16'($urandom_range(65535, 32769));
      default: return 16'($urandom_range(32768, 0));
    endcase
  endfunction

  function automatic logic [1:0] pick_mode();
    case ($urandom_range(9))
      0, 1, 2: return MODE_FEEDFORWARD;
      3, 4, 5: return MODE_FEEDBACK;
      9: return MODE_UNUSED;
      default: return MODE_UNIVERSAL;
    endcase
  endfunction

  initial begin
    int sent_random;
    int count;
    int phase;
    bit pause_mid;
    sb = new();
    sent_random = 0;
    phase = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: saturation both ways and a fresh line.
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    wait_drained();
    settings++;

    // Feedback echo, zero delay and a gain above one.
    write_reg(REG_MODE, {14'd0, MODE_FEEDBACK});
    write_reg(REG_ECHO_GAIN, 16'hFFFF);
    write_reg(REG_DELAY, 16'd0);
    send_sample(16'd1000, 1'b0);
    send_sample(16'd1000, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'd12345, 1'b0);
    send_sample(16'h0000, 1'b0);
    wait_drained();
    settings++;

    // Unused mode code and a delay beyond the store.
    write_reg(REG_MODE, {14'd0, MODE_UNUSED});
    write_reg(REG_DELAY, 16'hFFFF);
    send_sample(16'h4000, 1'b1);
    send_sample(16'hC000, 1'b0);
    wait_drained();
    settings++;

    // Universal comb with extreme coefficients.
    write_reg(REG_MODE, {14'd0, MODE_UNIVERSAL});
    write_reg(REG_FEEDFORWARD, 16'h8000);
    write_reg(REG_FEEDBACK, 16'h7FFF);
    write_reg(REG_BLEND, 16'h8000);
    write_reg(REG_DELAY, 16'd2);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h8000, 1'b0);
    send_sample(16'd20000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'd5, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    wait_drained();
    settings++;

    while (sent_random < RANDOM_TARGET) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      wait_drained();
      write_reg(REG_MODE, {14'($urandom()), pick_mode()});
      write_reg(REG_DELAY, pick_delay());
      write_reg(REG_ECHO_GAIN, pick_gain());
      write_reg(REG_FEEDFORWARD, pick_coef());
      write_reg(REG_FEEDBACK, pick_coef());
      write_reg(REG_BLEND, pick_coef());
      settings++;
      count = $urandom_range(160, 60);
      pause_mid = (phase % 3 == 1) || ($urandom_range(3) == 0);
      for (int i = 0; i < count; i++) begin
        if (pause_mid && i == count / 2) wait_drained();
        send_sample(pick_sample(),
                    (i == 0 && $urandom_range(1) == 1) || $urandom_range(63) == 0);
        sent_random++;
      end
      phase++;
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d samples under %0d register settings, %0d with the start flag,",
             sb.samples, settings, restarts);
    $display("with idle and stall patterns on both sides; %0d echoed samples compared.",
             sb.compared);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/aedl_pkg.sv
hdl/aedl_ctrl.sv
hdl/aedl_dp.sv
hdl/audio_echo_delay_line_top.sv
verif/tb_echo_pkg.sv
verif/tb_top.sv
